// File: hdl/lspfe_pkg.sv
// Package for the LED string pulse frame encoder.
// Holds the item structs, the timing struct, register indexes and frame constants.
// No dependencies.
`default_nettype none

package lspfe_pkg;

  localparam int unsigned FRAME_BITS = 26;
  localparam int unsigned BIT_CNT_W  = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LOW   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BRI_LIMIT  = 3'd6;

  // reset values
  localparam logic [7:0] RST_ONE_LOW    = 8'd18;
  localparam logic [7:0] RST_ONE_HIGH   = 8'd8;
  localparam logic [7:0] RST_ZERO_LOW   = 8'd8;
  localparam logic [7:0] RST_ZERO_HIGH  = 8'd20;
  localparam logic [7:0] RST_START_HIGH = 8'd10;
  localparam logic [7:0] RST_IDLE_LOW   = 8'd30;
  localparam logic [7:0] RST_BRI_LIMIT  = 8'd204;

  typedef struct packed {
    logic [2:0] column;
    logic [2:0] row;
    logic [3:0] red;
    logic [3:0] green;
    logic [3:0] blue;
    logic [7:0] brightness;
  } in_item_t;

  typedef struct packed {
    logic       line_level;
    logic [7:0] duration;
    logic       last_segment;
  } out_item_t;

  typedef struct packed {
    logic [7:0] one_low;
    logic [7:0] one_high;
    logic [7:0] zero_low;
    logic [7:0] zero_high;
    logic [7:0] start_high;
    logic [7:0] idle_low;
  } timing_t;

endpackage

`default_nettype wire

// File: hdl/lspfe_seq.sv
// Segment sequencer: walks a 26-bit frame MSB first and emits (level, duration) items.
// Depends on lspfe_pkg; timing values come from the top level's registers.
`default_nettype none

module lspfe_seq
  import lspfe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  frame_valid,
  output logic                       frame_ready,
  input  wire logic [FRAME_BITS-1:0] frame,
  input  wire timing_t               timing,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_BIT_LOW,
    ST_BIT_HIGH,
    ST_END
  } state_t;

  state_t                 state_r, state_nxt;
  logic [FRAME_BITS-1:0]  shift_r, shift_nxt;
  logic [BIT_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r, out_item_nxt;
  logic                   advance;
  logic                   cur_bit;

  assign advance     = !out_valid_r || out_ready;
  assign cur_bit     = shift_r[FRAME_BITS-1];
  assign frame_ready = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_data    = out_item_r;

  always_comb begin
    state_nxt     = state_r;
    shift_nxt     = shift_r;
    cnt_nxt       = cnt_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (frame_valid) begin
          shift_nxt = frame;
          cnt_nxt   = BIT_CNT_W'(FRAME_BITS - 1);
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (advance) begin
          out_item_nxt  = '{line_level: 1'b1, duration: timing.start_high, last_segment: 1'b0};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_BIT_LOW;
        end
      end
      ST_BIT_LOW: begin
        if (advance) begin
          out_item_nxt  = '{line_level: 1'b0,
                            duration: cur_bit ? timing.one_low : timing.zero_low,
                            last_segment: 1'b0};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_BIT_HIGH;
        end
      end
      ST_BIT_HIGH: begin
        if (advance) begin
          out_item_nxt  = '{line_level: 1'b1,
                            duration: cur_bit ? timing.one_high : timing.zero_high,
                            last_segment: 1'b0};
          out_valid_nxt = 1'b1;
          shift_nxt     = {shift_r[FRAME_BITS-2:0], 1'b0};
          if (cnt_r == '0) begin
            state_nxt = ST_END;
          end else begin
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = ST_BIT_LOW;
          end
        end
      end
      ST_END: begin
        if (advance) begin
          out_item_nxt  = '{line_level: 1'b0, duration: timing.idle_low, last_segment: 1'b1};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    shift_r    <= shift_nxt;
    out_item_r <= out_item_nxt;
  end

  // bit counter never runs past the frame
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= BIT_CNT_W'(FRAME_BITS - 1))
    else $error("bit counter out of range");

  // a taken frame closes the input until its closing segment is loaded
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    frame_valid && frame_ready |=> !frame_ready)
    else $error("ready held after accept");

  // closing segment is always a low level
  a_last_is_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.last_segment |-> !out_item_r.line_level)
    else $error("last segment not low");

  // the start segment is the first item after a frame is taken
  a_start_first: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_START && advance |=> out_valid_r && out_item_r.line_level
      && !out_item_r.last_segment)
    else $error("start segment malformed");

endmodule

`default_nettype wire

// File: hdl/led_string_pulse_frame_encoder_top.sv
// LED string pulse frame encoder, top level: configuration registers, brightness clamp,
// frame assembly; segments come from lspfe_seq. Depends on lspfe_pkg.
// The start segment is loaded from ST_START, the state after the one that accepts the item.
// Throughput: 54 segments per item, one per cycle while out_ready is high; the next item
// is taken the cycle after the closing segment is loaded, even while that segment still
// waits on out_ready.
// Reset: timing and limit registers return to their defaults, no item in flight.
`default_nettype none

module led_string_pulse_frame_encoder_top
  import lspfe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  timing_t               timing_r;
  logic [7:0]            bri_limit_r;
  logic [7:0]            bri_clamped;
  logic [FRAME_BITS-1:0] frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.one_low    <= RST_ONE_LOW;
      timing_r.one_high   <= RST_ONE_HIGH;
      timing_r.zero_low   <= RST_ZERO_LOW;
      timing_r.zero_high  <= RST_ZERO_HIGH;
      timing_r.start_high <= RST_START_HIGH;
      timing_r.idle_low   <= RST_IDLE_LOW;
      bri_limit_r         <= RST_BRI_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ONE_LOW:    timing_r.one_low    <= cfg_wdata;
        REG_ONE_HIGH:   timing_r.one_high   <= cfg_wdata;
        REG_ZERO_LOW:   timing_r.zero_low   <= cfg_wdata;
        REG_ZERO_HIGH:  timing_r.zero_high  <= cfg_wdata;
        REG_START_HIGH: timing_r.start_high <= cfg_wdata;
        REG_IDLE_LOW:   timing_r.idle_low   <= cfg_wdata;
        REG_BRI_LIMIT:  bri_limit_r         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign bri_clamped = (in_data.brightness > bri_limit_r) ? bri_limit_r : in_data.brightness;

  // address (row, column), brightness, blue, green, red - sent MSB first
  assign frame = {in_data.row, in_data.column, bri_clamped,
                  in_data.blue, in_data.green, in_data.red};

  lspfe_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (in_valid),
    .frame_ready (in_ready),
    .frame       (frame),
    .timing      (timing_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire
